// ===== rtl/kgr_pkg.sv =====
package kgr_pkg;

  localparam int VALUE_W = 32;
  localparam int GS_W    = 5;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } kgr_state_t;

endpackage

// ===== rtl/kgr_if.sv =====
interface kgr_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [kgr_pkg::VALUE_W-1:0]    item_value;
  logic                                  is_final;

  modport source (output valid, output item_value, output is_final, input ready);
  modport sink   (input valid, input item_value, input is_final, output ready);
endinterface

interface kgr_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [kgr_pkg::VALUE_W-1:0]    out_value;
  logic                                  run_last;
  logic                                  list_end;

  modport source (output valid, output out_value, output run_last, output list_end,
                  input ready);
  modport sink   (input valid, input out_value, input run_last, input list_end,
                  output ready);
endinterface

// ===== rtl/kgr_ram.sv =====
module kgr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/stream_k_group_reverser.sv =====
// channel   dir   handshake         payload
// in_ch     in    valid / ready     item_value[31:0] signed, is_final
// out_ch    out   valid / ready     out_value[31:0] signed, run_last, list_end
// cfg       in    cfg_we            cfg_wdata[4:0] = group size k
//
// Items are written into the group RAM at one per cycle while gathering.
// A beat that closes a group (or ends the list) starts a burst of n results;
// the burst reads the RAM at one entry per cycle while out_ch does not stall,
// with the input held off. The RAM read register
// is the output stage; a stall freezes the read enable.
// Reset (synchronous, rst_n low) empties the buffer and sets k to 1.
module stream_k_group_reverser #(
  parameter int K_MAX = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  kgr_in_if.sink                      in_ch,
  kgr_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [kgr_pkg::GS_W-1:0]    cfg_wdata
);

  localparam int CW   = $clog2(K_MAX + 1);
  localparam int AW   = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int CMPW = (CW > kgr_pkg::GS_W) ? CW : kgr_pkg::GS_W;

  kgr_pkg::kgr_state_t state_r, state_nxt;

  logic [kgr_pkg::GS_W-1:0] group_size_r;
  logic [CW-1:0]            held_r, held_nxt;
  logic [CW-1:0]            drain_n_r, drain_n_nxt;
  logic [CW-1:0]            rd_idx_r, rd_idx_nxt;
  logic                     rev_r, rev_nxt;
  logic                     fin_r, fin_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     run_last_r, run_last_nxt;
  logic                     list_end_r, list_end_nxt;

  logic [CMPW-1:0] gs_ext;
  logic [CMPW-1:0] k_eff;
  logic [CMPW-1:0] n_ext;
  logic            in_acc;
  logic            group_done;
  logic            start_burst;
  logic            issue;
  logic            issue_last;
  logic [CW-1:0]   rev_idx;
  logic [AW-1:0]   rd_addr;
  logic [kgr_pkg::VALUE_W-1:0] rd_data;

  // clamp k into 1..K_MAX
  assign gs_ext = CMPW'(group_size_r);
  always_comb begin
    if (gs_ext == '0) begin
      k_eff = CMPW'(1);
    end else if (gs_ext > CMPW'(K_MAX)) begin
      k_eff = CMPW'(K_MAX);
    end else begin
      k_eff = gs_ext;
    end
  end

  assign in_ch.ready  = (state_r == kgr_pkg::ST_FILL);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign n_ext        = CMPW'(held_r) + CMPW'(1);
  assign group_done   = (n_ext >= k_eff);
  assign start_burst  = in_acc && (group_done || in_ch.is_final);

  assign issue      = (state_r == kgr_pkg::ST_DRAIN) && (!out_valid_r || out_ch.ready);
  assign issue_last = ((rd_idx_r + CW'(1)) == drain_n_r);
  assign rev_idx    = drain_n_r - CW'(1) - rd_idx_r;
  assign rd_addr    = rev_r ? rev_idx[AW-1:0] : rd_idx_r[AW-1:0];

  kgr_ram #(
    .WIDTH(kgr_pkg::VALUE_W),
    .DEPTH(K_MAX)
  ) u_buf (
    .clk   (clk),
    .we    (in_acc),
    .waddr (held_r[AW-1:0]),
    .wdata (in_ch.item_value),
    .re    (issue),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kgr_pkg::ST_FILL: begin
        if (start_burst) begin
          state_nxt = kgr_pkg::ST_DRAIN;
        end
      end
      kgr_pkg::ST_DRAIN: begin
        if (issue && issue_last) begin
          state_nxt = kgr_pkg::ST_FILL;
        end
      end
      default: state_nxt = kgr_pkg::ST_FILL;
    endcase
  end

  // datapath and outputs
  always_comb begin
    held_nxt      = held_r;
    drain_n_nxt   = drain_n_r;
    rd_idx_nxt    = rd_idx_r;
    rev_nxt       = rev_r;
    fin_nxt       = fin_r;
    run_last_nxt  = run_last_r;
    list_end_nxt  = list_end_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    case (state_r)
      kgr_pkg::ST_FILL: begin
        if (start_burst) begin
          held_nxt    = '0;
          drain_n_nxt = CW'(n_ext);
          rd_idx_nxt  = '0;
          rev_nxt     = group_done;
          fin_nxt     = in_ch.is_final;
        end else if (in_acc) begin
          held_nxt = CW'(n_ext);
        end
      end
      kgr_pkg::ST_DRAIN: begin
        if (issue) begin
          out_valid_nxt = 1'b1;
          run_last_nxt  = issue_last;
          list_end_nxt  = issue_last && fin_r;
          rd_idx_nxt    = rd_idx_r + CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= kgr_pkg::ST_FILL;
      group_size_r <= kgr_pkg::GS_W'(1);
      held_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        group_size_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    drain_n_r  <= drain_n_nxt;
    rd_idx_r   <= rd_idx_nxt;
    rev_r      <= rev_nxt;
    fin_r      <= fin_nxt;
    run_last_r <= run_last_nxt;
    list_end_r <= list_end_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_value = rd_data;
  assign out_ch.run_last  = run_last_r;
  assign out_ch.list_end  = list_end_r;

  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    CMPW'(held_r) < CMPW'(K_MAX))
    else $error("held count reached buffer depth");

  a_burst_start: assert property (@(posedge clk) disable iff (!rst_n)
    start_burst |=> (state_r == kgr_pkg::ST_DRAIN) && (held_r == '0))
    else $error("burst did not start after group close");

  a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && issue_last) |=> (state_r == kgr_pkg::ST_FILL) && out_valid_r && run_last_r)
    else $error("burst did not end on its last beat");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && list_end_r) |-> run_last_r)
    else $error("list end without run last");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == kgr_pkg::ST_DRAIN) |-> (rd_idx_r < drain_n_r))
    else $error("read index past burst length");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int VALUE_W     = kgr_pkg::VALUE_W;
  localparam int GS_W        = kgr_pkg::GS_W;
  localparam int K_DEPTH     = 16;
  localparam int DRAIN_SLACK = 16;
  localparam int LONG_HOLD   = 300;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      run_last;
    logic                      list_end;
  } reordered_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [GS_W-1:0] cfg_wdata;

  kgr_in_if  in_bus ();
  kgr_out_if out_bus ();

  stream_k_group_reverser #(
    .K_MAX (K_DEPTH)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // group reordering model
  logic signed [VALUE_W-1:0] gathered [K_DEPTH];
  int                        gathered_n;
  logic [GS_W-1:0]           k_model;
  reordered_t                pending_order [$];

  int  err_count;
  int  items_in;
  int  results_checked;
  int  cfg_writes;
  int  bursts_reversed;
  int  tails_ordered;
  bit  in_gaps_on;
  bit  out_stalls_on;
  bit  hold_off_req;

  function automatic void reorder_item(input logic signed [VALUE_W-1:0] v,
                                       input logic last_of_list);
    reordered_t beat;
    int keff;
    int n;
    keff = (k_model == 0) ? 1 : ((k_model > K_DEPTH) ? K_DEPTH : int'(k_model));
    if (gathered_n >= K_DEPTH) gathered_n = 0;
    gathered[gathered_n] = v;
    gathered_n++;
    n = gathered_n;
    if (n >= keff || last_of_list) begin
      for (int i = 0; i < n; i++) begin
        // a full group comes out newest first, a short tail in arrival order
        beat.value    = (n >= keff) ? gathered[n-1-i] : gathered[i];
        beat.run_last = (i == n - 1);
        beat.list_end = (i == n - 1) && last_of_list;
        pending_order.push_back(beat);
      end
      if (n >= keff) bursts_reversed++;
      else tails_ordered++;
      gathered_n = 0;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 8);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return 32'sh0000_0000;
      3: return 32'shFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // drive one beat and wait for it to be taken
  task automatic push_item(input logic signed [VALUE_W-1:0] v, input logic last_of_list);
    int gap;
    bit took;
    gap = in_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.item_value <= v;
    in_bus.is_final   <= last_of_list;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = (in_bus.ready === 1'b1);
      @(posedge clk);
    end
    items_in++;
    reorder_item(v, last_of_list);
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (pending_order.size() != 0) @(posedge clk);
    // allow a burst still in flight behind a held group to settle
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic set_group_size(input logic [GS_W-1:0] k);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= k;
    @(posedge clk);
    cfg_we    <= 1'b0;
    k_model = k;
    cfg_writes++;
  endtask

  task automatic send_list(input int n, input bit broken);
    logic fin;
    for (int i = 0; i < n; i++) begin
      fin = broken ? ($urandom_range(0, 3) == 0) : (i == n - 1);
      push_item(pick_value(), fin);
    end
  endtask

  task automatic test_pass_through_extremes();
    set_group_size(5'd1);
    push_item(32'sh7FFF_FFFF, 1'b0);
    push_item(32'sh8000_0000, 1'b0);
    push_item(32'sh0000_0000, 1'b0);
    push_item(32'shFFFF_FFFF, 1'b1);
  endtask

  task automatic test_short_tail_max_k();
    set_group_size(5'd16);
    push_item(32'sh0000_0011, 1'b0);
    push_item(32'sh5555_5555, 1'b0);
    push_item(32'shAAAA_AAAA, 1'b1);
  endtask

  task automatic test_final_closes_group();
    set_group_size(5'd3);
    push_item(32'sh0000_0001, 1'b0);
    push_item(32'sh0000_0002, 1'b0);
    push_item(32'sh0000_0003, 1'b1);
    push_item(32'sh1234_5678, 1'b1);
  endtask

  task automatic test_zero_group_size();
    set_group_size(5'd0);
    push_item(32'sh0BAD_F00D, 1'b0);
    push_item(32'shF00D_0BAD, 1'b1);
  endtask

  task automatic test_shrink_mid_group();
    set_group_size(5'd8);
    for (int i = 0; i < 5; i++) push_item(32'sh100 + i, 1'b0);
    // five held, lower k below that: next beat releases all six reversed
    set_group_size(5'd3);
    push_item(32'sh0000_0105, 1'b0);
    push_item(32'sh0000_0106, 1'b1);
  endtask

  task automatic test_backpressure_fill();
    set_group_size(5'd4);
    in_gaps_on   = 1'b0;
    hold_off_req = 1'b1;
    repeat (39) push_item(pick_value(), 1'b0);
    push_item(pick_value(), 1'b1);
    wait_drained();
  endtask

  task automatic test_random_lists();
    logic [GS_W-1:0] plan [10];
    int phase_items;
    int n;
    int keff;
    int mode;
    plan = '{5'd16, 5'd31, 5'd1, 5'd2, 5'd5, 5'd0, 5'd7, 5'd3, 5'd12, 5'd9};
    for (int p = 0; p < 10; p++) begin
      set_group_size(p == 9 ? 5'($urandom_range(1, 16)) : plan[p]);
      keff = (k_model == 0) ? 1 : ((k_model > K_DEPTH) ? K_DEPTH : int'(k_model));
      phase_items = 0;
      while (phase_items < 27) begin
        mode = $urandom_range(0, 3);
        in_gaps_on    = mode[0];
        out_stalls_on = mode[1];
        n = $urandom_range(1, 2 * keff + 2);
        send_list(n, $urandom_range(0, 9) == 0);
        phase_items += n;
      end
    end
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    push_item(pick_value(), 1'b1);
    wait_drained();
  endtask

  // result side: random stalls, plus one long hold when asked
  initial begin : drive_ready
    int len;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (out_stalls_on && $urandom_range(0, 2) == 0) begin
        out_bus.ready <= 1'b0;
        len = pick_gap() + 1;
        repeat (len) @(posedge clk);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // sample at the falling edge; the beat completes at the next rising edge
  always @(negedge clk) begin : check_results
    reordered_t want;
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (pending_order.size() == 0) begin
        $error("unexpected result beat: out_value %0d", out_bus.out_value);
        err_count++;
      end else begin
        want = pending_order.pop_front();
        results_checked++;
        if (out_bus.out_value !== want.value) begin
          $error("out_value: expected %0d, got %0d", want.value, out_bus.out_value);
          err_count++;
        end
        if (out_bus.run_last !== want.run_last) begin
          $error("run_last: expected %0b, got %0b", want.run_last, out_bus.run_last);
          err_count++;
        end
        if (out_bus.list_end !== want.list_end) begin
          $error("list_end: expected %0b, got %0b", want.list_end, out_bus.list_end);
          err_count++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    err_count       = 0;
    items_in        = 0;
    results_checked = 0;
    cfg_writes      = 0;
    bursts_reversed = 0;
    tails_ordered   = 0;
    gathered_n      = 0;
    k_model         = 5'd1;
    in_gaps_on      = 1'b1;
    out_stalls_on   = 1'b1;
    hold_off_req    = 1'b0;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    in_bus.valid      <= 1'b0;
    in_bus.item_value <= '0;
    in_bus.is_final   <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_pass_through_extremes();
    test_short_tail_max_k();
    test_final_closes_group();
    test_zero_group_size();
    test_shrink_mid_group();
    test_backpressure_fill();
    test_random_lists();

    $display("tb_top: %0d beats sent, %0d result beats checked, %0d group size writes",
             items_in, results_checked, cfg_writes);
    $display("tb_top: %0d groups reversed, %0d short tails passed in order",
             bursts_reversed, tails_ordered);
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
